### src/hcla_pkg.sv
// Shared constants for the hierarchical cohort lock arbiter.
package hcla_pkg;

    localparam int STW = 14;
    localparam int CFGW = 12;

    localparam logic [STW-1:0] ST_WAIT         = 14'h3FFF;
    localparam logic [STW-1:0] ST_ACQ_PARENT   = 14'h3FFE;
    localparam logic [STW-1:0] ST_COHORT_START = 14'd1;

    localparam logic [CFGW-1:0] THRESHOLD_RESET = 12'd256;

    localparam logic [1:0] FN_ACQUIRE = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_QUERY   = 2'd2;

endpackage

### src/hierarchical_cohort_lock_arbiter.sv
// Hierarchical queue lock arbiter: request sequencer over queue-node and tree-node memories.
// A rejected or ignored request is answered directly; an acquire climbs level by level until
// it links behind a waiter or is granted at the root, a holder's query looks for waiters
// level by level, and a release climbs the tree and wakes waiters on the way back down.
// One request is taken at a time; s_tready returns with m_tvalid when the result is staged.
// Reset (aresetn low, synchronous) clears control, holder and valid bits; threshold goes to 256.
module hierarchical_cohort_lock_arbiter
    import hcla_pkg::*;
#(
    parameter int THREADS    = 64,
    parameter int LEAF_GROUP = 2,
    parameter int MID_GROUP  = 16,
    parameter int LEVELS     = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFGW-1:0]  cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [1:0] func, [7:2] thread
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata    // [0] grant_valid, [6:1] grant_thread,
                                        // [7] no_waiters, [8] protocol_error, rest zero
);

    localparam int NLEAF  = (THREADS + LEAF_GROUP - 1) / LEAF_GROUP;
    localparam int NMID   = (LEVELS >= 3) ? (THREADS + MID_GROUP - 1) / MID_GROUP : 0;
    localparam int NNODES = NLEAF + NMID + 1;
    localparam int NQ     = THREADS + NNODES;
    localparam int TW     = $clog2(THREADS);
    localparam int NW     = $clog2(NNODES);
    localparam int QW     = $clog2(NQ + 1);   // one spare code for null
    localparam int QIW    = $clog2(NQ);
    localparam int SPW    = $clog2(LEVELS + 1);
    localparam int SIW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [QW-1:0] QNULL    = '1;
    localparam logic [NW-1:0] ROOT     = NW'(NNODES - 1);
    localparam logic [QW-1:0] Q_THREAD = QW'(THREADS);

    typedef enum logic [4:0] {
        S_IDLE, S_ACQ_T1, S_ACQ_T2, S_ACQ_T3, S_A1, S_A2,
        S_W1, S_W2, S_W3, S_RU0, S_RU1, S_MR0, S_MR1, S_RET,
        S_Q0, S_Q1, S_Q2, S_QF, S_DONE
    } state_t;

    function automatic logic [NW-1:0] parent_of(input logic [NW-1:0] n);
        if (LEVELS >= 3 && int'(n) < NLEAF)
            return NW'(NLEAF + (int'(n) * LEAF_GROUP) / MID_GROUP);
        return ROOT;
    endfunction

    function automatic logic [NW-1:0] leaf_of(input logic [TW-1:0] t);
        return NW'(int'(t) / LEAF_GROUP);
    endfunction

    function automatic logic [QW-1:0] own_q(input logic [NW-1:0] n);
        return Q_THREAD + QW'(n);
    endfunction

    // Memories: queue-node successor and status, tree-node tail and leader.
    logic [QW-1:0]  qn_mem [NQ];
    logic [STW-1:0] qs_mem [NQ];
    logic [QW-1:0]  tl_mem [NNODES];
    logic [TW-1:0]  ld_mem [NNODES];

    logic [NQ-1:0]     qn_vld_reg, qs_vld_reg;
    logic [NNODES-1:0] tl_vld_reg;
    logic              qn_rvld_reg, qs_rvld_reg, tl_rvld_reg;
    logic [QW-1:0]     qn_raw_reg, tl_raw_reg;
    logic [STW-1:0]    qs_raw_reg;
    logic [TW-1:0]     ld_rd;

    logic [QIW-1:0] q_raddr;
    logic [NW-1:0]  t_raddr, l_raddr;
    logic           qn_we, qs_we, tl_we, ld_we;
    logic [QIW-1:0] qn_waddr, qs_waddr;
    logic [NW-1:0]  tl_waddr, ld_waddr;
    logic [QW-1:0]  qn_wdata, tl_wdata;
    logic [STW-1:0] qs_wdata;
    logic [TW-1:0]  ld_wdata;

    logic [QW-1:0]  qn_rd, tl_rd;
    logic [STW-1:0] qs_rd;

    assign qn_rd = qn_rvld_reg ? qn_raw_reg : QNULL;
    assign qs_rd = qs_rvld_reg ? qs_raw_reg : ST_WAIT;
    assign tl_rd = tl_rvld_reg ? tl_raw_reg : QNULL;

    always_ff @(posedge aclk) begin
        if (qn_we) qn_mem[qn_waddr] <= qn_wdata;
        if (qs_we) qs_mem[qs_waddr] <= qs_wdata;
        if (tl_we) tl_mem[tl_waddr] <= tl_wdata;
        if (ld_we) ld_mem[ld_waddr] <= ld_wdata;
        qn_raw_reg <= qn_mem[q_raddr];
        qs_raw_reg <= qs_mem[q_raddr];
        tl_raw_reg <= tl_mem[t_raddr];
        ld_rd      <= ld_mem[l_raddr];
    end

    // Valid bits: an entry never written reads as its reset code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qn_vld_reg  <= '0;
            qs_vld_reg  <= '0;
            tl_vld_reg  <= '0;
            qn_rvld_reg <= 1'b0;
            qs_rvld_reg <= 1'b0;
            tl_rvld_reg <= 1'b0;
        end else begin
            qn_rvld_reg <= qn_vld_reg[q_raddr];
            qs_rvld_reg <= qs_vld_reg[q_raddr];
            tl_rvld_reg <= tl_vld_reg[t_raddr];
            if (qn_we) qn_vld_reg[qn_waddr] <= 1'b1;
            if (qs_we) qs_vld_reg[qs_waddr] <= 1'b1;
            if (tl_we) tl_vld_reg[tl_waddr] <= 1'b1;
        end
    end

    // Sequencer registers.
    state_t         state_reg, state_next;
    logic [NW-1:0]  cn_reg, cn_next, cm_reg, cm_next;
    logic [QW-1:0]  cq_reg, cq_next, cs_reg, cs_next;
    logic [TW-1:0]  ct_reg, ct_next;
    logic [STW-1:0] cv_reg, cv_next;
    logic           lt_null_reg, lt_null_next;
    logic [SPW-1:0] sp_reg, sp_next, sp_dec;
    logic [NW-1:0]  stk_n_reg [LEVELS];
    logic [QW-1:0]  stk_q_reg [LEVELS];
    logic           stk_push;
    logic [THREADS-1:0] fp_reg, fp_next, act_reg, act_next;
    logic           hold_vld_reg, hold_vld_next;
    logic [TW-1:0]  hold_reg, hold_next;
    logic           res_gv_reg, res_gv_next, res_nw_reg, res_nw_next, res_err_reg, res_err_next;
    logic [TW-1:0]  res_gt_reg, res_gt_next;
    logic [CFGW-1:0] thr_reg;
    logic           m_tvalid_reg;
    logic [15:0]    m_tdata_reg;

    logic [1:0]     in_func;
    logic [5:0]     in_thr;
    logic [TW-1:0]  tin;
    logic           in_bad;
    logic [TW-1:0]  cs_t;
    logic [NW-1:0]  cs_node, m_sel;

    assign in_func = s_tdata[1:0];
    assign in_thr  = s_tdata[7:2];
    assign tin     = TW'(in_thr);
    assign in_bad  = int'(in_thr) >= THREADS;
    assign cs_t    = TW'(cs_reg);
    assign cs_node = NW'(cs_reg - Q_THREAD);
    assign sp_dec  = sp_reg - 1'b1;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        cn_next       = cn_reg;
        cm_next       = cm_reg;
        cq_next       = cq_reg;
        cs_next       = cs_reg;
        ct_next       = ct_reg;
        cv_next       = cv_reg;
        lt_null_next  = lt_null_reg;
        sp_next       = sp_reg;
        stk_push      = 1'b0;
        fp_next       = fp_reg;
        act_next      = act_reg;
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        res_gv_next   = res_gv_reg;
        res_gt_next   = res_gt_reg;
        res_nw_next   = res_nw_reg;
        res_err_next  = res_err_reg;
        m_sel         = '0;
        q_raddr  = '0;
        t_raddr  = '0;
        l_raddr  = '0;
        qn_we    = 1'b0; qn_waddr = '0; qn_wdata = QNULL;
        qs_we    = 1'b0; qs_waddr = '0; qs_wdata = ST_WAIT;
        tl_we    = 1'b0; tl_waddr = '0; tl_wdata = QNULL;
        ld_we    = 1'b0; ld_waddr = '0; ld_wdata = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_gv_next  = 1'b0;
                    res_gt_next  = '0;
                    res_nw_next  = 1'b0;
                    res_err_next = 1'b0;
                    sp_next      = '0;
                    ct_next      = tin;
                    state_next   = S_DONE;
                    if (in_func == FN_ACQUIRE || in_func == FN_RELEASE || in_func == FN_QUERY)
                        res_err_next = in_bad;
                    if (!in_bad) begin
                        case (in_func)
                            FN_ACQUIRE: begin
                                if (act_reg[tin]) begin
                                    res_err_next = 1'b1;
                                end else begin
                                    act_next[tin] = 1'b1;
                                    state_next    = S_ACQ_T1;
                                end
                            end
                            FN_RELEASE: begin
                                if (!(hold_vld_reg && hold_reg == tin)) begin
                                    res_err_next = 1'b1;
                                end else begin
                                    hold_vld_next = 1'b0;
                                    act_next[tin] = 1'b0;
                                    cq_next       = QW'(tin);
                                    if (fp_reg[tin]) begin
                                        // fast-path holder leaves the root queue directly
                                        fp_next[tin] = 1'b0;
                                        cn_next      = ROOT;
                                        cv_next      = ST_COHORT_START;
                                        state_next   = S_MR0;
                                    end else begin
                                        cn_next    = leaf_of(tin);
                                        state_next = S_RU0;
                                    end
                                end
                            end
                            FN_QUERY: begin
                                if (hold_vld_reg && hold_reg == tin)
                                    state_next = S_Q0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_ACQ_T1: begin
                t_raddr    = leaf_of(ct_reg);
                state_next = S_ACQ_T2;
            end
            S_ACQ_T2: begin
                lt_null_next = (tl_rd == QNULL);
                t_raddr      = ROOT;
                state_next   = S_ACQ_T3;
            end
            S_ACQ_T3: begin
                cq_next = QW'(ct_reg);
                if (lt_null_reg && tl_rd == QNULL) begin
                    fp_next[ct_reg] = 1'b1;
                    cn_next         = ROOT;
                end else begin
                    cn_next = leaf_of(ct_reg);
                end
                state_next = S_A1;
            end
            S_A1: begin
                qs_we = 1'b1; qs_waddr = cq_reg[QIW-1:0]; qs_wdata = ST_WAIT;
                qn_we = 1'b1; qn_waddr = cq_reg[QIW-1:0]; qn_wdata = QNULL;
                t_raddr    = cn_reg;
                state_next = S_A2;
            end
            S_A2: begin
                tl_we = 1'b1; tl_waddr = cn_reg; tl_wdata = cq_reg;
                if (tl_rd != QNULL) begin
                    // link behind the predecessor and wait
                    qn_we = 1'b1; qn_waddr = tl_rd[QIW-1:0]; qn_wdata = cq_reg;
                    state_next = S_RET;
                end else if (cn_reg == ROOT) begin
                    hold_vld_next = 1'b1;
                    hold_next     = ct_reg;
                    res_gv_next   = 1'b1;
                    res_gt_next   = ct_reg;
                    state_next    = S_RET;
                end else begin
                    // first in group: lead the cohort and climb
                    qs_we = 1'b1; qs_waddr = cq_reg[QIW-1:0]; qs_wdata = ST_COHORT_START;
                    ld_we = 1'b1; ld_waddr = cn_reg; ld_wdata = ct_reg;
                    cq_next    = own_q(cn_reg);
                    cn_next    = parent_of(cn_reg);
                    state_next = S_A1;
                end
            end
            S_W1: begin
                qs_we = 1'b1; qs_waddr = cs_reg[QIW-1:0]; qs_wdata = cv_reg;
                if (cs_reg < Q_THREAD) begin
                    m_sel   = fp_reg[cs_t] ? ROOT : leaf_of(cs_t);
                    ct_next = cs_t;
                    cm_next = m_sel;
                    if (cv_reg != ST_ACQ_PARENT || m_sel == ROOT) begin
                        hold_vld_next = 1'b1;
                        hold_next     = cs_t;
                        res_gv_next   = 1'b1;
                        res_gt_next   = cs_t;
                        state_next    = S_RET;
                    end else begin
                        state_next = S_W3;
                    end
                end else begin
                    l_raddr    = cs_node;
                    state_next = S_W2;
                end
            end
            S_W2: begin
                m_sel   = parent_of(cs_node);
                ct_next = ld_rd;
                cm_next = m_sel;
                if (cv_reg != ST_ACQ_PARENT || m_sel == ROOT) begin
                    hold_vld_next = 1'b1;
                    hold_next     = ld_rd;
                    res_gv_next   = 1'b1;
                    res_gt_next   = ld_rd;
                    state_next    = S_RET;
                end else begin
                    state_next = S_W3;
                end
            end
            S_W3: begin
                qs_we = 1'b1; qs_waddr = cs_reg[QIW-1:0]; qs_wdata = ST_COHORT_START;
                ld_we = 1'b1; ld_waddr = cm_reg; ld_wdata = ct_reg;
                cn_next    = parent_of(cm_reg);
                cq_next    = own_q(cm_reg);
                state_next = S_A1;
            end
            S_RU0: begin
                if (cn_reg == ROOT) begin
                    cv_next    = ST_COHORT_START;
                    state_next = S_MR0;
                end else begin
                    q_raddr    = cq_reg[QIW-1:0];
                    state_next = S_RU1;
                end
            end
            S_RU1: begin
                if (qs_rd < STW'(thr_reg) && qn_rd != QNULL) begin
                    // hand off inside the cohort with a raised pass count
                    cs_next    = qn_rd;
                    cv_next    = qs_rd + 1'b1;
                    state_next = S_W1;
                end else begin
                    // release the parent first, then this level
                    stk_push   = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    cq_next    = own_q(cn_reg);
                    cn_next    = parent_of(cn_reg);
                    state_next = S_RU0;
                end
            end
            S_MR0: begin
                q_raddr    = cq_reg[QIW-1:0];
                t_raddr    = cn_reg;
                state_next = S_MR1;
            end
            S_MR1: begin
                if (qn_rd != QNULL) begin
                    cs_next    = qn_rd;
                    state_next = S_W1;
                end else begin
                    if (tl_rd == cq_reg) begin
                        tl_we = 1'b1; tl_waddr = cn_reg; tl_wdata = QNULL;
                    end
                    state_next = S_RET;
                end
            end
            S_RET: begin
                if (sp_reg != '0) begin
                    cn_next    = stk_n_reg[sp_dec[SIW-1:0]];
                    cq_next    = stk_q_reg[sp_dec[SIW-1:0]];
                    cv_next    = ST_ACQ_PARENT;
                    sp_next    = sp_dec;
                    state_next = S_MR0;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_Q0: begin
                if (fp_reg[ct_reg]) begin
                    q_raddr    = QIW'(ct_reg);
                    state_next = S_QF;
                end else begin
                    cq_next    = QW'(ct_reg);
                    cn_next    = leaf_of(ct_reg);
                    state_next = S_Q1;
                end
            end
            S_Q1: begin
                q_raddr    = cq_reg[QIW-1:0];
                state_next = S_Q2;
            end
            S_Q2: begin
                if (qn_rd != QNULL) begin
                    state_next = S_DONE;
                end else if (cn_reg == ROOT) begin
                    res_nw_next = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cq_next    = own_q(cn_reg);
                    cn_next    = parent_of(cn_reg);
                    state_next = S_Q1;
                end
            end
            S_QF: begin
                res_nw_next = (qn_rd == QNULL);
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sp_reg       <= '0;
            fp_reg       <= '0;
            act_reg      <= '0;
            hold_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            thr_reg      <= THRESHOLD_RESET;
        end else begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            fp_reg       <= fp_next;
            act_reg      <= act_next;
            hold_vld_reg <= hold_vld_next;
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
            // stage the result; drop it once taken
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cn_reg      <= cn_next;
        cm_reg      <= cm_next;
        cq_reg      <= cq_next;
        cs_reg      <= cs_next;
        ct_reg      <= ct_next;
        cv_reg      <= cv_next;
        lt_null_reg <= lt_null_next;
        hold_reg    <= hold_next;
        res_gv_reg  <= res_gv_next;
        res_gt_reg  <= res_gt_next;
        res_nw_reg  <= res_nw_next;
        res_err_reg <= res_err_next;
        if (stk_push) begin
            stk_n_reg[sp_reg[SIW-1:0]] <= cn_reg;
            stk_q_reg[sp_reg[SIW-1:0]] <= cq_reg;
        end
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
            m_tdata_reg <= {7'd0, res_err_reg, res_nw_reg, 6'(res_gt_reg), res_gv_reg};
    end

endmodule

### src/hcla_checker.sv
// Port-level checker for the hierarchical cohort lock arbiter, with its bind.
module hcla_port_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
        else $error("grant thread set without grant");

    a_error_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> !m_tdata[0] && !m_tdata[7])
        else $error("rejected request changed the lock");

    a_query_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> !m_tdata[0])
        else $error("query produced a grant");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:9] == 7'd0)
        else $error("result padding not zero");

endmodule

bind hierarchical_cohort_lock_arbiter hcla_port_props u_hcla_port_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
